/* sv/csad_pkg.sv */
`timescale 1ns / 1ps

package csad_pkg;

  // default width of the in-window point counter
  localparam int COUNT_BITS_DEF = 16;

  // shared serial divider
  localparam int DIV_W  = 32;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] RES_STEPS = 6'd24;
  localparam logic [STEP_W-1:0] FIN_STEPS = 6'd32;

  // saturation limits of |z| in Q8.16
  localparam logic [23:0] DEV_POS_MAX = 24'd8388607;
  localparam logic [23:0] DEV_NEG_MAX = 24'd8388608;

  // register reset values
  localparam logic [31:0] THRESHOLD_RST = 32'd131072;
  localparam logic [15:0] SCALE_LO_RST  = 16'd16;
  localparam logic [15:0] SCALE_HI_RST  = 16'd16000;
  localparam logic [15:0] MIN_COUNT_RST = 16'd3;

  // register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SCALE_LO  = 2'd1,
    CFG_SCALE_HI  = 2'd2,
    CFG_MIN_COUNT = 2'd3
  } csad_cfg_idx_t;

  typedef struct packed {
    logic [31:0] threshold;
    logic [15:0] scale_lo;
    logic [15:0] scale_hi;
    logic [15:0] min_count;
  } csad_cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } csad_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } csad_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_ABS,
    ST_RANGE,
    ST_DIVIDE,
    ST_SQUARE,
    ST_ACCUM,
    ST_CLOSE,
    ST_REDUCE,
    ST_EMIT
  } csad_state_t;

endpackage

/* sv/csad_in_if.sv */
`timescale 1ns / 1ps

interface csad_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] angular_scale;
  logic signed [31:0] observed_shear;
  logic signed [31:0] shear_error;
  logic signed [31:0] predicted_shear;
  logic               final_point;

  modport source (
    output valid, angular_scale, observed_shear, shear_error, predicted_shear, final_point,
    input  ready
  );

  modport sink (
    input  valid, angular_scale, observed_shear, shear_error, predicted_shear, final_point,
    output ready
  );
endinterface

/* sv/csad_out_if.sv */
`timescale 1ns / 1ps

interface csad_out_if;
  logic        valid;
  logic        ready;
  logic        anomaly_found;
  logic        enough_points;
  logic [31:0] reduced_chi_square;
  logic [23:0] largest_deviation;
  logic [15:0] points_used;

  modport source (
    output valid, anomaly_found, enough_points, reduced_chi_square, largest_deviation,
           points_used,
    input  ready
  );

  modport sink (
    input  valid, anomaly_found, enough_points, reduced_chi_square, largest_deviation,
           points_used,
    output ready
  );
endinterface

/* sv/csad_cfg_regs.sv */
`timescale 1ns / 1ps

module csad_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output csad_pkg::csad_cfg_t  cfg_o
);
  import csad_pkg::*;

  csad_cfg_t cfg_r;
  csad_cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (csad_cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: cfg_nxt.threshold = cfg_data;
        CFG_SCALE_LO:  cfg_nxt.scale_lo  = cfg_data[15:0];
        CFG_SCALE_HI:  cfg_nxt.scale_hi  = cfg_data[15:0];
        CFG_MIN_COUNT: cfg_nxt.min_count = cfg_data[15:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.scale_lo  <= SCALE_LO_RST;
      cfg_r.scale_hi  <= SCALE_HI_RST;
      cfg_r.min_count <= MIN_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* sv/csad_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module csad_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csad_pkg::csad_div_req_t  req_i,
  output csad_pkg::csad_div_rsp_t  rsp_o
);
  import csad_pkg::*;

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [STEP_W-1:0] cnt_r,   cnt_nxt;
  logic [DIV_W-1:0]  rem_r,   rem_nxt;
  logic [DIV_W-1:0]  quo_r,   quo_nxt;
  logic [DIV_W-1:0]  dsr_r,   dsr_nxt;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_sub;
  logic              fits;

  // shift in next dividend bit and try the subtract
  always_comb begin
    trial     = {rem_r, quo_r[DIV_W-1]};
    trial_sub = trial - {1'b0, dsr_r};
    fits      = trial >= {1'b0, dsr_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req_i.steps;
      rem_nxt  = req_i.rem_init;
      quo_nxt  = req_i.dividend;
      dsr_nxt  = req_i.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = quo_r;

endmodule

/* sv/chi_square_anomaly_detector_core.sv */
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_chan   in   valid / ready      angular_scale, observed/predicted_shear, shear_error,
//                                   final_point
// out_chan  out  valid / ready      anomaly_found, enough_points, reduced_chi_square,
//                                   largest_deviation, points_used
// cfg_*     in   cfg_we (no stall)  cfg_index, cfg_data
//
// one request at a time: an in-window point with positive error goes window, abs, range,
// the 24-step divider, square, accumulate, close; a saturating residual skips the divider,
// other points go window to close; a final point adds a 32-step divide of the sum and a load
// in_chan.ready is high only in the idle state; a waiting result does not block input,
// the next result waits in the emit state until the output register is free
// rst_n is synchronous: registers back to defaults, accumulators cleared

module chi_square_anomaly_detector_core #(
  parameter int COUNT_BITS = csad_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  csad_in_if.sink     in_chan,
  csad_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import csad_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  csad_cfg_t     cfg;
  csad_div_req_t div_req;
  csad_div_rsp_t div_rsp;

  csad_state_t state_r, state_nxt;

  // request payload
  logic [15:0] scale_r,  scale_nxt;
  logic [31:0] obs_r,    obs_nxt;
  logic [31:0] err_r,    err_nxt;
  logic [31:0] pred_r,   pred_nxt;
  logic        last_r,   last_nxt;

  // residual datapath
  logic [32:0] diff_r,   diff_nxt;
  logic [32:0] mag_r,    mag_nxt;
  logic        neg_r,    neg_nxt;
  logic [23:0] q_r,      q_nxt;
  logic [47:0] sq_r,     sq_nxt;
  logic [31:0] red_r,    red_nxt;

  // accumulators
  logic [47:0]           sum_r,   sum_nxt;
  logic [23:0]           peak_r,  peak_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  // output register
  logic        out_valid_r,   out_valid_nxt;
  logic        anomaly_r,     anomaly_nxt;
  logic        enough_r,      enough_nxt;
  logic [31:0] out_red_r,     out_red_nxt;
  logic [23:0] out_dev_r,     out_dev_nxt;
  logic [15:0] out_used_r,    out_used_nxt;

  logic        in_window;
  logic        err_pos;
  logic        overflow;
  logic [23:0] cap;
  logic [23:0] q_div;
  logic [48:0] sum_add;
  logic [31:0] count_ext;
  logic        enough;
  logic        out_free;

  csad_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  csad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // shared terms
  always_comb begin
    in_window = (scale_r >= cfg.scale_lo) && (scale_r <= cfg.scale_hi);
    err_pos   = !err_r[31] && (err_r != '0);
    overflow  = {6'b0, mag_r} >= {err_r[30:0], 8'b0};
    cap       = neg_r ? DEV_NEG_MAX : DEV_POS_MAX;
    q_div     = div_rsp.quotient[23:0];
    sum_add   = {1'b0, sum_r} + {1'b0, sq_r};
    count_ext = 32'(count_r);
    enough    = (count_r != '0) && (count_ext >= 32'(cfg.min_count));
    out_free  = !out_valid_r || out_chan.ready;
  end

  // state machine and datapath
  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    obs_nxt       = obs_r;
    err_nxt       = err_r;
    pred_nxt      = pred_r;
    last_nxt      = last_r;
    diff_nxt      = diff_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    q_nxt         = q_r;
    sq_nxt        = sq_r;
    red_nxt       = red_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    anomaly_nxt   = anomaly_r;
    enough_nxt    = enough_r;
    out_red_nxt   = out_red_r;
    out_dev_nxt   = out_dev_r;
    out_used_nxt  = out_used_r;
    in_chan.ready = 1'b0;

    div_req.start    = 1'b0;
    div_req.steps    = RES_STEPS;
    div_req.rem_init = {7'b0, mag_r[32:8]};
    div_req.dividend = {mag_r[7:0], 24'b0};
    div_req.divisor  = {1'b0, err_r[30:0]};

    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          scale_nxt = in_chan.angular_scale;
          obs_nxt   = in_chan.observed_shear;
          err_nxt   = in_chan.shear_error;
          pred_nxt  = in_chan.predicted_shear;
          last_nxt  = in_chan.final_point;
          state_nxt = ST_WINDOW;
        end
      end
      // window check, count, raw residual
      ST_WINDOW: begin
        diff_nxt = {obs_r[31], obs_r} - {pred_r[31], pred_r};
        if (in_window && count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
        state_nxt = (in_window && err_pos) ? ST_ABS : ST_CLOSE;
      end
      ST_ABS: begin
        neg_nxt   = diff_r[32];
        mag_nxt   = diff_r[32] ? (33'd0 - diff_r) : diff_r;
        state_nxt = ST_RANGE;
      end
      // quotient of 2^24 or more saturates without dividing
      ST_RANGE: begin
        if (overflow) begin
          q_nxt     = cap;
          state_nxt = ST_SQUARE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          q_nxt     = (q_div > cap) ? cap : q_div;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        sq_nxt    = 48'(q_r) * 48'(q_r);
        state_nxt = ST_ACCUM;
      end
      // saturating sum and running peak
      ST_ACCUM: begin
        sum_nxt = sum_add[48] ? {48{1'b1}} : sum_add[47:0];
        if (q_r > peak_r) begin
          peak_nxt = q_r;
        end
        state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        div_req.steps    = FIN_STEPS;
        div_req.rem_init = '0;
        div_req.dividend = sum_r[47:16];
        div_req.divisor  = count_ext;
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          red_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (div_rsp.done) begin
          red_nxt   = div_rsp.quotient;
          state_nxt = ST_EMIT;
        end
      end
      // load output register and clear accumulators together
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          enough_nxt    = enough;
          anomaly_nxt   = enough && (red_r > cfg.threshold);
          out_red_nxt   = red_r;
          out_dev_nxt   = peak_r;
          out_used_nxt  = (count_ext > 32'hFFFF) ? 16'hFFFF : count_ext[15:0];
          sum_nxt       = '0;
          peak_nxt      = '0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scale_r    <= scale_nxt;
    obs_r      <= obs_nxt;
    err_r      <= err_nxt;
    pred_r     <= pred_nxt;
    last_r     <= last_nxt;
    diff_r     <= diff_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    sq_r       <= sq_nxt;
    red_r      <= red_nxt;
    anomaly_r  <= anomaly_nxt;
    enough_r   <= enough_nxt;
    out_red_r  <= out_red_nxt;
    out_dev_r  <= out_dev_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.anomaly_found      = anomaly_r;
  assign out_chan.enough_points      = enough_r;
  assign out_chan.reduced_chi_square = out_red_r;
  assign out_chan.largest_deviation  = out_dev_r;
  assign out_chan.points_used        = out_used_r;

endmodule
